FILE: design/assert_macros.svh
// Assertion macros used by the RTL of the extended-real multiplier.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
// check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: design/efm_pkg.sv
// Package for the extended-real multiplier: field widths and constants.
// Used by extended_float_multiply_top.
`timescale 1ns / 1ps
`default_nettype none
package efm_pkg;
	localparam int unsigned MANT_W = 64;
	localparam int unsigned SE_W   = 16;
	localparam int unsigned EXP_W  = 15;
	localparam logic [EXP_W-1:0] EXP_BIAS = 15'd16383;
	localparam logic [EXP_W-1:0] EXP_MAX  = 15'h7fff;
	// 18-bit signed working exponent range
	typedef logic signed [17:0] exp_t;
endpackage
`default_nettype wire

FILE: design/extended_float_multiply_top.sv
// Top level of the extended-real multiplier: a five-stage pipeline.
// Depends on efm_pkg and assert_macros.svh.
//
// channel | dir | tdata fields (low bit up)                  | tuser
// s_axis  | in  | sign_exp_a[15:0] mant_a sign_exp_b mant_b   | none
// m_axis  | out | sign_exp_r[15:0] mant_r[79:16] overflow[80] | none
//
// One beat in per cycle while m_axis does not stall; each beat passes through
// the four 32x32 partial products, their sum, a leading-zero count, the
// shift choice and the shift.
// Reset clears only the stage valid bits. A stall at m_axis freezes every
// stage together; no beat is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module extended_float_multiply_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [159:0] s_axis_tdata,  // sign_exp_a, mant_a, sign_exp_b, mant_b
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [87:0]       m_axis_tdata   // sign_exp_r, mant_r, overflow, zero pad
);
	import efm_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	assign adv = m_axis_tready || !v_s5;
	assign s_axis_tready = adv;

	// input fields
	logic [SE_W-1:0] sa, sb;
	logic [MANT_W-1:0] ma, mb;
	assign sa = s_axis_tdata[15:0];
	assign ma = s_axis_tdata[79:16];
	assign sb = s_axis_tdata[95:80];
	assign mb = s_axis_tdata[159:96];

	// stage 1: exponent sum and partial products
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	exp_t e_s1;
	logic sg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s1 <= ma[31:0] * mb[31:0];
			lh_s1 <= ma[31:0] * mb[63:32];
			hl_s1 <= ma[63:32] * mb[31:0];
			hh_s1 <= ma[63:32] * mb[63:32];
			e_s1  <= exp_t'({3'b0, sa[14:0]}) + exp_t'({3'b0, sb[14:0]})
				- exp_t'({3'b0, EXP_BIAS}) + 18'sd1;
			sg_s1 <= sa[15] ^ sb[15];
		end
	end

	// stage 2: sum partial products
	logic [127:0] p_s2;
	exp_t e_s2;
	logic sg_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2  <= {64'b0, ll_s1} + {32'b0, lh_s1, 32'b0} + {32'b0, hl_s1, 32'b0}
				+ {hh_s1, 64'b0};
			e_s2  <= e_s1;
			sg_s2 <= sg_s1;
		end
	end

	// stage 3: leading-zero count
	function automatic logic [7:0] lzc(input logic [127:0] v);
		logic [7:0] n;
		logic done;
		n = 8'd128;
		done = 1'b0;
		for (int i = 127; i >= 0; i--) begin
			if (!done && v[i]) begin
				n = 8'(127 - i);
				done = 1'b1;
			end
		end
		return n;
	endfunction
	logic [127:0] p_s3;
	exp_t e_s3;
	logic [7:0] lz_s3;
	logic sg_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3  <= p_s2;
			e_s3  <= e_s2;
			lz_s3 <= lzc(p_s2);
			sg_s3 <= sg_s2;
		end
	end

	// stage 4: pick the shift, the final exponent and the under/overflow flags
	logic [127:0] p_s4;
	logic [EXP_W-1:0] e_s4;
	logic [6:0] sh_s4;
	logic sg_s4, uf_s4, of_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4  <= p_s3;
			sg_s4 <= sg_s3;
			uf_s4 <= e_s3 < 0;
			of_s4 <= e_s3 > exp_t'({3'b0, EXP_MAX});
			if (lz_s3 == 8'd128) begin
				sh_s4 <= '0;
				e_s4  <= '0;
			end else if (exp_t'({10'b0, lz_s3}) >= e_s3) begin
				sh_s4 <= e_s3[6:0];
				e_s4  <= '0;
			end else begin
				sh_s4 <= lz_s3[6:0];
				e_s4  <= EXP_W'(e_s3 - exp_t'({10'b0, lz_s3}));
			end
		end
	end

	// stage 5: shift and form the result
	logic [15:0] se_s5;
	logic [63:0] m_s5;
	logic of_s5;
	logic [127:0] shd;
	assign shd = p_s4 << sh_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			of_s5 <= of_s4 && !uf_s4;
			if (uf_s4) begin
				se_s5 <= {sg_s4, 15'b0};
				m_s5  <= '0;
			end else if (of_s4) begin
				se_s5 <= '0;
				m_s5  <= '0;
			end else begin
				se_s5 <= {sg_s4, e_s4};
				m_s5  <= shd[127:64];
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {7'b0, of_s5, m_s5, se_s5};

	`ASSERT_IMPL(a_of_zero, clk, arst_n, v_s5 && of_s5, se_s5 == 16'd0 && m_s5 == 64'd0)
	`ASSERT_IMPL(a_hold, clk, arst_n, v_s5 && !m_axis_tready, ##1 (v_s5 && $stable(m_s5)))
	`ASSERT_IMPL(a_norm, clk, arst_n, v_s5 && se_s5[14:0] != 15'd0 && !of_s5, m_s5[63])
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Testbench for extended_float_multiply_top: random and directed extended-real products
// checked beat by beat against a behavioural multiplier. Depends on efm_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
	import efm_pkg::*;

	typedef struct packed {
		logic [63:0] mant_b;
		logic [15:0] sign_exp_b;
		logic [63:0] mant_a;
		logic [15:0] sign_exp_a;
	} operands_t;

	typedef struct {
		logic [15:0] sign_exp;
		logic [63:0] mant;
		logic        ovf;
	} product_t;

	localparam int LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [87:0]  m_axis_tdata;

	operands_t pending_ops[$];
	product_t  expected_products[$];
	int        errors = 0;
	int        n_checked = 0;
	int        n_sent = 0;
	int        cycle = 0;
	int        hold_off = 0;
	bit        calm = 0;
	bit        in_taken = 0;

	extended_float_multiply_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// work out the extended-real product of one operand pair
	function automatic product_t multiply_extended(operands_t op);
		product_t      r;
		logic [127:0]  prod;
		int            e;
		logic [15:0]   sign;
		sign = (op.sign_exp_a ^ op.sign_exp_b) & 16'h8000;
		e = int'(op.sign_exp_a[14:0]) + int'(op.sign_exp_b[14:0]) - 16383 + 1;
		r.ovf = 1'b0;
		r.mant = '0;
		if (e < 0) begin
			r.sign_exp = sign;
		end else if (e > 32'h7fff) begin
			r.sign_exp = '0;
			r.ovf = 1'b1;
		end else begin
			prod = 128'(op.mant_a) * 128'(op.mant_b);
			if (prod == '0) begin
				e = 0;
			end else begin
				while (e != 0 && !prod[127]) begin
					e--;
					prod = prod << 1;
				end
			end
			r.sign_exp = 16'(e) | sign;
			r.mant = prod[127:64];
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_mant();
		case ($urandom_range(0, 5))
			0: return 64'h0;
			1: return {1'b1, 63'h0} | ({$urandom, $urandom} >> $urandom_range(1, 63));
			2: return {$urandom, $urandom} >> $urandom_range(0, 63);
			3: return 64'hffff_ffff_ffff_ffff;
			default: return {1'b1, $urandom, 31'($urandom)};
		endcase
	endfunction

	function automatic logic [15:0] rand_se();
		logic s;
		s = 1'($urandom);
		case ($urandom_range(0, 5))
			0: return {s, 15'($urandom_range(16200, 16560))};
			1: return {s, 15'($urandom_range(0, 200))};
			2: return {s, 15'($urandom_range(32500, 32767))};
			3: return {s, 15'($urandom_range(8000, 8400))};
			default: return 16'($urandom);
		endcase
	endfunction

	// note at the rising edge whether the offered beat was taken
	always @(posedge clk) begin
		in_taken = s_axis_tvalid && s_axis_tready;
	end

	// drive beats at the falling edge, idling at random outside the calm stretch
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) n_sent++;
			if (!s_axis_tvalid || in_taken) begin
				if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
					s_axis_tdata <= pending_ops.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// accept beats with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || $urandom_range(0, 99) >= 20;
			end
		end
	end

	// sample results at the rising edge and compare with the oldest expectation
	always @(posedge clk) begin
		product_t exp_p;
		cycle++;
		if (cycle > LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_products.size() == 0) begin
				$error("result beat with no expectation waiting: %h", m_axis_tdata);
				errors++;
			end else begin
				exp_p = expected_products.pop_front();
				n_checked++;
				if (m_axis_tdata[15:0] !== exp_p.sign_exp) begin
					$error("sign_exp_r expected %h actual %h", exp_p.sign_exp, m_axis_tdata[15:0]);
					errors++;
				end
				if (m_axis_tdata[79:16] !== exp_p.mant) begin
					$error("mant_r expected %h actual %h", exp_p.mant, m_axis_tdata[79:16]);
					errors++;
				end
				if (m_axis_tdata[80] !== exp_p.ovf) begin
					$error("overflow expected %b actual %b", exp_p.ovf, m_axis_tdata[80]);
					errors++;
				end
			end
		end
	end

	task automatic queue_op(logic [15:0] sa, logic [63:0] ma, logic [15:0] sb, logic [63:0] mb);
		operands_t op;
		op.sign_exp_a = sa;
		op.mant_a = ma;
		op.sign_exp_b = sb;
		op.mant_b = mb;
		pending_ops.push_back(op);
		expected_products.push_back(multiply_extended(op));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: one times one, signs, extremes, underflow, overflow, zero, exhausted exponent
		queue_op(16'h3fff, 64'h8000_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000);
		queue_op(16'hbfff, 64'hc000_0000_0000_0000, 16'h3fff, 64'ha000_0000_0000_0000);
		queue_op(16'hffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff);
		queue_op(16'h0000, 64'h0, 16'h0000, 64'h0);
		queue_op(16'h8000, 64'h8000_0000_0000_0000, 16'h0001, 64'h8000_0000_0000_0000);
		queue_op(16'h1fff, 64'h8000_0000_0000_0000, 16'h9fff, 64'h8000_0000_0000_0000);
		queue_op(16'h1fff, 64'h8000_0000_0000_0000, 16'h1ffe, 64'h8000_0000_0000_0000);
		queue_op(16'h7fff, 64'h8000_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000);
		queue_op(16'h7fff, 64'h8000_0000_0000_0000, 16'h4000, 64'h8000_0000_0000_0000);
		queue_op(16'hc000, 64'h8000_0000_0000_0000, 16'h3fff, 64'h0);
		queue_op(16'h3ffe, 64'h0000_0000_0000_0001, 16'h0001, 64'h0000_0000_0000_0001);
		queue_op(16'h3fff, 64'h0000_0000_0000_0001, 16'h3fff, 64'h0000_0000_0000_0001);
		queue_op(16'h2000, 64'h0000_0001_0000_0000, 16'h2000, 64'h4000_0000_0000_0000);
		queue_op(16'h3fff, 64'hffff_ffff_ffff_ffff, 16'h0000, 64'h8000_0000_0000_0001);
		queue_op(16'h4000, 64'h5555_5555_5555_5555, 16'hc000, 64'haaaa_aaaa_aaaa_aaaa);

		// long hold-off on the receiver while the sender keeps offering
		calm = 1;
		hold_off = 60;
		for (int i = 0; i < 1000; i++) queue_op(rand_se(), rand_mant(), rand_se(), rand_mant());
		wait (pending_ops.size() < 800);
		calm = 0;
		wait (pending_ops.size() < 300);
		calm = 1;
		wait (pending_ops.size() < 150);
		calm = 0;
		wait (pending_ops.size() == 0 && !s_axis_tvalid);
		wait (expected_products.size() == 0);
		repeat (20) @(posedge clk);
		$display("checked %0d products over %0d operand beats, incl. under/overflow and zeros",
			n_checked, n_sent);
		if (errors == 0 && expected_products.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
